@@ rtl/rtq_pkg.sv @@
// Shared package for the repeating timer queue unit.
// Holds word layout, item mode codes and the controller/datapath command and status types.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rtq_pkg;

	// Defaults for the top level parameters
	localparam int DEF_NUM_TIMERS = 16;
	localparam int DEF_TIME_BITS  = 48;

	// Input word fields
	localparam int MODE_W   = 2;
	localparam int SLOT_W   = 4;
	localparam int PERIOD_W = 32;
	localparam int REPEAT_W = 32;
	localparam int IN_W     = 72;

	// Result word fields
	localparam int OUT_W = 8;

	// At most this many firings are reported per tick
	localparam int MAX_FIRE = 16;
	localparam int FIRE_W   = $clog2(MAX_FIRE);

	// Item modes
	localparam logic [MODE_W-1:0] MODE_ADD    = 2'd0;
	localparam logic [MODE_W-1:0] MODE_CANCEL = 2'd1;
	localparam logic [MODE_W-1:0] MODE_TICK   = 2'd2;

	// Controller to datapath
	typedef struct packed {
		logic take_item; // input word accepted this cycle
		logic scan_run;  // step the slot scan
		logic fire;      // fire the best due timer
		logic flush;     // emit the held result as the last of the tick
	} rtq_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic in_tick;    // input word is a tick
		logic scan_done;  // all slots issued
		logic best_valid; // scan found a due timer
		logic held_valid; // a fired result waits for its last flag
		logic out_free;   // output register can load this cycle
		logic fire_limit; // this firing is the last allowed in the tick
	} rtq_stat_t;

endpackage

`default_nettype wire

@@ rtl/rtq_ctrl.sv @@
// Controller state machine of the repeating timer queue unit.
// Sequences item intake, slot scans, firings and the final flush; depends on rtq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rtq_ctrl (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               in_valid,
	output logic              in_ready,
	input  rtq_pkg::rtq_stat_t stat,
	output rtq_pkg::rtq_cmd_t  cmd
);
	import rtq_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_SCAN   = 4'b0010,
		ST_DECIDE = 4'b0100,
		ST_FLUSH  = 4'b1000
	} state_t;

	state_t state_q, state_d;

	// Intake only while idle
	assign in_ready = (state_q == ST_IDLE);

	// Next state and commands
	always_comb begin
		state_d       = state_q;
		cmd.take_item = 1'b0;
		cmd.scan_run  = 1'b0;
		cmd.fire      = 1'b0;
		cmd.flush     = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.take_item = 1'b1;
					if (stat.in_tick) begin
						state_d = ST_SCAN;
					end
				end
			end
			ST_SCAN: begin
				cmd.scan_run = 1'b1;
				if (stat.scan_done) begin
					state_d = ST_DECIDE;
				end
			end
			ST_DECIDE: begin
				if (stat.best_valid) begin
					// previous result must leave before a new one is held
					if (!stat.held_valid || stat.out_free) begin
						cmd.fire = 1'b1;
						state_d  = stat.fire_limit ? ST_FLUSH : ST_SCAN;
					end
				end else if (stat.held_valid) begin
					state_d = ST_FLUSH;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_FLUSH: begin
				if (stat.out_free) begin
					cmd.flush = 1'b1;
					state_d   = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// A firing needs a due timer found by the scan
	a_fire_best: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.fire |-> stat.best_valid)
		else $error("fire without a due timer");

	// A flush always has a held result to emit
	a_flush_held: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.flush |-> stat.held_valid)
		else $error("flush with nothing held");

	// Reaching the firing limit ends the tick with a flush
	a_limit_flush: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.fire && stat.fire_limit) |=> (state_q == ST_FLUSH))
		else $error("firing limit did not end the tick");

endmodule

`default_nettype wire

@@ rtl/rtq_datapath.sv @@
// Datapath of the repeating timer queue unit: time counter, slot memories,
// active bits, earliest-deadline scan, held result and output register; depends on rtq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rtq_datapath #(
	parameter int NUM_TIMERS = rtq_pkg::DEF_NUM_TIMERS,
	parameter int TIME_BITS  = rtq_pkg::DEF_TIME_BITS
) (
	input  wire                       clk,
	input  wire                       arst_n,
	input  rtq_pkg::rtq_cmd_t         cmd,
	output rtq_pkg::rtq_stat_t        stat,
	input  wire  [rtq_pkg::IN_W-1:0]  in_data,
	output logic                      out_valid,
	input  wire                       out_ready,
	output logic [rtq_pkg::OUT_W-1:0] out_data,
	output logic                      out_last
);
	import rtq_pkg::*;

	localparam int AW = $clog2(NUM_TIMERS);
	localparam int CW = $clog2(NUM_TIMERS + 1);

	// Input word fields
	logic [MODE_W-1:0]   in_mode;
	logic [SLOT_W-1:0]   in_slot;
	logic [PERIOD_W-1:0] in_period;
	logic [REPEAT_W-1:0] in_repeat;
	logic [PERIOD_W-1:0] period_fix;
	logic                slot_ok;

	assign in_mode    = in_data[MODE_W-1:0];
	assign in_slot    = in_data[MODE_W +: SLOT_W];
	assign in_period  = in_data[MODE_W+SLOT_W +: PERIOD_W];
	assign in_repeat  = in_data[MODE_W+SLOT_W+PERIOD_W +: REPEAT_W];
	assign period_fix = (in_period == '0) ? PERIOD_W'(1) : in_period;
	assign slot_ok    = (32'(in_slot) < 32'(NUM_TIMERS));

	// Slot storage
	logic [TIME_BITS-1:0] deadline_mem [NUM_TIMERS];
	logic [PERIOD_W-1:0]  period_mem   [NUM_TIMERS];
	logic [REPEAT_W-1:0]  repeats_mem  [NUM_TIMERS];
	logic [NUM_TIMERS-1:0] active_q;
	logic [TIME_BITS-1:0] now_q;

	// Scan state
	logic [CW-1:0]        idx_q;
	logic                 valid_s1;
	logic [AW-1:0]        idx_s1;
	logic [TIME_BITS-1:0] rd_deadline_s1;
	logic [PERIOD_W-1:0]  rd_period_s1;
	logic [REPEAT_W-1:0]  rd_repeats_s1;
	logic                 best_valid_q;
	logic [AW-1:0]        best_idx_q;
	logic [TIME_BITS-1:0] best_age_q;
	logic [PERIOD_W-1:0]  best_period_q;
	logic [REPEAT_W-1:0]  best_repeats_q;

	// Fired result waiting for its last flag
	logic                 held_valid_q;
	logic [SLOT_W-1:0]    held_slot_q;
	logic                 held_rearm_q;
	logic [FIRE_W-1:0]    fire_cnt_q;

	// Output register
	logic                 out_valid_q;
	logic [SLOT_W-1:0]    out_slot_q;
	logic                 out_rearm_q;
	logic                 out_last_q;

	// Item decode
	logic is_add, is_cancel, is_tick;
	always_comb begin
		is_add    = 1'b0;
		is_cancel = 1'b0;
		is_tick   = 1'b0;
		case (in_mode)
			MODE_ADD:    is_add    = 1'b1;
			MODE_CANCEL: is_cancel = 1'b1;
			MODE_TICK:   is_tick   = 1'b1;
			default:     ;
		endcase
	end

	logic do_add, do_cancel, do_tick, again, out_free;
	assign do_add    = cmd.take_item && is_add && slot_ok;
	assign do_cancel = cmd.take_item && is_cancel && slot_ok;
	assign do_tick   = cmd.take_item && is_tick;
	assign again     = (best_repeats_q > REPEAT_W'(1));
	assign out_free  = !out_valid_q || out_ready;

	// Shared write port: add from the input word, re-arm from the best timer
	logic [AW-1:0]        wr_addr;
	logic [PERIOD_W-1:0]  addend;
	logic [TIME_BITS-1:0] wr_deadline;
	logic [REPEAT_W-1:0]  wr_repeats;
	logic                 we_deadline, we_period, we_repeats;

	assign wr_addr     = do_add ? AW'(in_slot) : best_idx_q;
	assign addend      = do_add ? period_fix : best_period_q;
	assign wr_deadline = now_q + TIME_BITS'(addend);
	assign wr_repeats  = do_add ? in_repeat : (best_repeats_q - REPEAT_W'(1));
	assign we_deadline = do_add || (cmd.fire && again);
	assign we_repeats  = we_deadline;
	assign we_period   = do_add;

	// Slot memories, registered read at the scan index
	always_ff @(posedge clk) begin
		if (we_deadline) begin
			deadline_mem[wr_addr] <= wr_deadline;
		end
		if (we_period) begin
			period_mem[wr_addr] <= in_period == '0 ? period_fix : in_period;
		end
		if (we_repeats) begin
			repeats_mem[wr_addr] <= wr_repeats;
		end
		rd_deadline_s1 <= deadline_mem[idx_q[AW-1:0]];
		rd_period_s1   <= period_mem[idx_q[AW-1:0]];
		rd_repeats_s1  <= repeats_mem[idx_q[AW-1:0]];
		idx_s1         <= idx_q[AW-1:0];
	end

	// Age of the slot read last cycle; due when the age is below half range
	logic [TIME_BITS-1:0] age_s1;
	logic                 due_s1;
	logic                 better_s1;
	assign age_s1    = now_q - rd_deadline_s1;
	assign due_s1    = valid_s1 && active_q[idx_s1] && !age_s1[TIME_BITS-1];
	assign better_s1 = due_s1 && (!best_valid_q || (age_s1 > best_age_q));

	// Time, active bits, scan control, held result and fire count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			now_q        <= '0;
			active_q     <= '0;
			idx_q        <= '0;
			valid_s1     <= 1'b0;
			best_valid_q <= 1'b0;
			held_valid_q <= 1'b0;
			fire_cnt_q   <= '0;
		end else begin
			valid_s1 <= cmd.scan_run && (idx_q < CW'(NUM_TIMERS));
			if (do_add) begin
				active_q[AW'(in_slot)] <= 1'b1;
			end
			if (do_cancel) begin
				active_q[AW'(in_slot)] <= 1'b0;
			end
			if (do_tick) begin
				now_q        <= now_q + TIME_BITS'(1);
				idx_q        <= '0;
				best_valid_q <= 1'b0;
				fire_cnt_q   <= '0;
			end
			if (cmd.scan_run && (idx_q < CW'(NUM_TIMERS))) begin
				idx_q <= idx_q + CW'(1);
			end
			if (better_s1) begin
				best_valid_q <= 1'b1;
			end
			if (cmd.fire) begin
				if (!again) begin
					active_q[best_idx_q] <= 1'b0;
				end
				held_valid_q <= 1'b1;
				fire_cnt_q   <= fire_cnt_q + FIRE_W'(1);
				idx_q        <= '0;
				best_valid_q <= 1'b0;
			end
			if (cmd.flush) begin
				held_valid_q <= 1'b0;
			end
		end
	end

	// Best candidate and held result payload
	always_ff @(posedge clk) begin
		if (better_s1) begin
			best_idx_q     <= idx_s1;
			best_age_q     <= age_s1;
			best_period_q  <= rd_period_s1;
			best_repeats_q <= rd_repeats_s1;
		end
		if (cmd.fire) begin
			held_slot_q  <= SLOT_W'(best_idx_q);
			held_rearm_q <= again;
		end
	end

	// Output register: previous result leaves on a new firing, last one on flush
	logic out_load;
	assign out_load = (cmd.fire && held_valid_q) || cmd.flush;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_slot_q  <= held_slot_q;
			out_rearm_q <= held_rearm_q;
			out_last_q  <= cmd.flush;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = OUT_W'({out_rearm_q, out_slot_q});
	assign out_last  = out_last_q;

	// Status
	assign stat.in_tick    = is_tick;
	assign stat.scan_done  = (idx_q == CW'(NUM_TIMERS));
	assign stat.best_valid = best_valid_q;
	assign stat.held_valid = held_valid_q;
	assign stat.out_free   = out_free;
	assign stat.fire_limit = (fire_cnt_q == FIRE_W'(MAX_FIRE - 1));

	// A result is loaded only into a free output register
	a_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> out_free)
		else $error("output register overwritten");

	// Every firing leaves a held result behind
	a_fire_held: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.fire |=> held_valid_q)
		else $error("fired result not held");

	// No item is taken while a tick still has a result pending
	a_take_clean: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.take_item |-> !held_valid_q)
		else $error("item taken with a result pending");

endmodule

`default_nettype wire

@@ rtl/repeating_timer_queue_unit.sv @@
// Repeating timer queue unit: bank of repeating timers fired earliest deadline first.
// Top level joining rtq_ctrl and rtq_datapath; depends on rtq_pkg.
//
// Input channel s_*: one word per item. Add arms a slot at now + period, cancel
// clears a slot, tick advances the time counter by one and fires due timers.
// Output channel m_*: one word per fired timer, in order of earliest deadline,
// lower slot first on ties; m_tlast marks the final firing of a tick. Add,
// cancel and a tick with nothing due produce no output word.
// Add and cancel may follow each other every cycle.
// A tick keeps s_tready low while it runs: each search reads one slot per cycle
// (registered read), then fires the winner, and a tick that fired at least one
// timer ends with a flush of its last result.
// At most 16 timers fire per tick; the search after the sixteenth is skipped.
// A fired result is held until the next search decides whether it is the last,
// then moves to the output register, so the first word of a tick appears after
// the second search. When m_tready is low the block waits before a firing or flush,
// and s_tready stays low until the tick's last word is in the output register.
// Reset clears the time counter, all active bits and both channels; slot
// memories need no clearing since only active slots can be due.
`timescale 1ns / 1ps
`default_nettype none

module repeating_timer_queue_unit #(
	parameter int NUM_TIMERS = rtq_pkg::DEF_NUM_TIMERS,
	parameter int TIME_BITS  = rtq_pkg::DEF_TIME_BITS
) (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire                       s_tvalid,
	output logic                      s_tready,
	// mode[1:0], slot[5:2], period[37:6], repeat_count[69:38], zero fill
	input  wire  [rtq_pkg::IN_W-1:0]  s_tdata,
	output logic                      m_tvalid,
	input  wire                       m_tready,
	// fired_slot[3:0], rearmed[4], zero fill
	output logic [rtq_pkg::OUT_W-1:0] m_tdata,
	output logic                      m_tlast
);
	import rtq_pkg::*;

	rtq_cmd_t  cmd;
	rtq_stat_t stat;

	// Sequencer
	rtq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// Storage, scan and output
	rtq_datapath #(
		.NUM_TIMERS (NUM_TIMERS),
		.TIME_BITS  (TIME_BITS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.in_data   (s_tdata),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (m_tdata),
		.out_last  (m_tlast)
	);

endmodule

`default_nettype wire
